// ----- design/lscc_pkg.sv -----
// Shared types and constants for the LLC SAP connection control unit.
// No dependencies; every other file imports this package.
package lscc_pkg;

  localparam int unsigned SAP_W   = 8;
  localparam int unsigned STN_W   = 8;
  localparam int unsigned CTRL_W  = 3;
  localparam int unsigned OP_W    = 2;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 8;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W  = 1;
  localparam int unsigned QCNT_W  = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_SAP    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_VIRTUAL_MODE = 1'b1;

  typedef enum logic [OP_W-1:0] {
    OP_LISTEN = 2'd0,
    OP_CALL   = 2'd1,
    OP_HANGUP = 2'd2,
    OP_FRAME  = 2'd3
  } opcode_t;

  typedef enum logic [CTRL_W-1:0] {
    CC_UI   = 3'd0,
    CC_REQ  = 3'd1,
    CC_ACP  = 3'd2,
    CC_REJ  = 3'd3,
    CC_DISC = 3'd4
  } ctrl_t;

  typedef enum logic [1:0] {
    ST_SLEEPING   = 2'd0,
    ST_LISTENING  = 2'd1,
    ST_CONNECTING = 2'd2,
    ST_CONNECTED  = 2'd3
  } status_t;

  // Decoded request handed from the front end to the back end.
  typedef enum logic [2:0] {
    CMD_NOP     = 3'd0,
    CMD_LISTEN  = 3'd1,
    CMD_CALL    = 3'd2,
    CMD_HANGUP  = 3'd3,
    CMD_ACCEPT  = 3'd4,
    CMD_REJECT  = 3'd5,
    CMD_REQUEST = 3'd6
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [SAP_W-1:0]  peer_sap;
    logic [STN_W-1:0]  peer_station;
  } cmd_t;

endpackage

// ----- design/lscc_front.sv -----
// Front end: accepts requests and classifies them into decoded commands.
// Depends on lscc_pkg.
module lscc_front
  import lscc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              virtual_mode,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [OP_W-1:0]   in_opcode,
  input  logic [SAP_W-1:0]  in_peer_sap,
  input  logic [STN_W-1:0]  in_peer_station,
  input  logic [CTRL_W-1:0] in_control_code,
  output logic              cmd_valid,
  input  logic              cmd_ready,
  output cmd_t              cmd
);

  logic      valid_r, valid_nxt;
  cmd_t      cmd_r, cmd_nxt;
  cmd_kind_t kind;
  logic      take;

  always_comb begin
    kind = CMD_NOP;
    unique case (opcode_t'(in_opcode))
      OP_LISTEN: kind = virtual_mode ? CMD_LISTEN : CMD_NOP;
      OP_CALL:   kind = CMD_CALL;
      OP_HANGUP: kind = CMD_HANGUP;
      OP_FRAME: begin
        if (virtual_mode) begin
          unique case (in_control_code)
            CC_REQ:  kind = CMD_REQUEST;
            CC_ACP:  kind = CMD_ACCEPT;
            CC_REJ:  kind = CMD_REJECT;
            default: kind = CMD_NOP;
          endcase
        end
      end
      default: kind = CMD_NOP;
    endcase
  end

  assign in_ready = !valid_r || cmd_ready;
  assign take     = in_valid && in_ready;

  always_comb begin
    valid_nxt = valid_r;
    cmd_nxt   = cmd_r;
    if (take) begin
      valid_nxt            = 1'b1;
      cmd_nxt.kind         = kind;
      cmd_nxt.peer_sap     = in_peer_sap;
      cmd_nxt.peer_station = in_peer_station;
    end else if (cmd_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    cmd_r <= cmd_nxt;
  end

  assign cmd_valid = valid_r;
  assign cmd       = cmd_r;

endmodule

// ----- design/lscc_queue.sv -----
// Short command queue between the front end and the back end.
// Depends on lscc_pkg.
module lscc_queue
  import lscc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_cmd,
  output logic pop_valid,
  input  logic pop_ready,
  output cmd_t pop_cmd
);

  cmd_t              mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              push, pop;

  assign push_ready = (count_r != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_cmd    = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ----- design/lscc_back.sv -----
// Back end: connection state, command execution and the result register.
// Depends on lscc_pkg.
module lscc_back
  import lscc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic [SAP_W-1:0]  local_sap,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  input  cmd_t              cmd,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_send_valid,
  output logic [STN_W-1:0]  out_send_station,
  output logic [SAP_W-1:0]  out_send_dst_sap,
  output logic [SAP_W-1:0]  out_send_src_sap,
  output logic [CTRL_W-1:0] out_send_control,
  output logic [1:0]        out_link_status
);

  status_t          cur_r, cur_nxt;
  status_t          prev_r, prev_nxt;
  logic [SAP_W-1:0] conn_sap_r, conn_sap_nxt;
  logic [STN_W-1:0] conn_stn_r, conn_stn_nxt;

  logic              ovalid_r, ovalid_nxt;
  logic              send_r, send_nxt;
  logic [STN_W-1:0]  stn_r, stn_nxt;
  logic [SAP_W-1:0]  dsap_r, dsap_nxt;
  logic [SAP_W-1:0]  ssap_r, ssap_nxt;
  ctrl_t             ctrl_r, ctrl_nxt;
  status_t           stat_r, stat_nxt;

  logic    exec;
  logic    emit;
  ctrl_t   emit_ctrl;
  logic [STN_W-1:0] emit_stn;
  logic [SAP_W-1:0] emit_sap;

  assign cmd_ready = !ovalid_r || out_ready;
  assign exec      = cmd_valid && cmd_ready;

  always_comb begin
    cur_nxt      = cur_r;
    prev_nxt     = prev_r;
    conn_sap_nxt = conn_sap_r;
    conn_stn_nxt = conn_stn_r;
    emit         = 1'b0;
    emit_ctrl    = CC_UI;
    emit_stn     = cmd.peer_station;
    emit_sap     = cmd.peer_sap;

    unique case (cmd.kind)
      CMD_LISTEN: begin
        if (cur_r == ST_SLEEPING) begin
          prev_nxt = cur_r;
          cur_nxt  = ST_LISTENING;
        end
      end
      CMD_CALL: begin
        emit         = 1'b1;
        emit_ctrl    = CC_REQ;
        conn_sap_nxt = cmd.peer_sap;
        conn_stn_nxt = cmd.peer_station;
        prev_nxt     = cur_r;
        cur_nxt      = ST_CONNECTING;
      end
      CMD_HANGUP: begin
        if (cur_r == ST_CONNECTED) begin
          emit      = 1'b1;
          emit_ctrl = CC_DISC;
          emit_stn  = conn_stn_r;
          emit_sap  = conn_sap_r;
          cur_nxt   = prev_r;
        end
      end
      CMD_ACCEPT: begin
        prev_nxt = cur_r;
        cur_nxt  = ST_CONNECTED;
      end
      CMD_REJECT: begin
        cur_nxt = prev_r;
      end
      CMD_REQUEST: begin
        if (cur_r == ST_LISTENING) begin
          prev_nxt     = ST_LISTENING;
          cur_nxt      = ST_CONNECTED;
          conn_sap_nxt = cmd.peer_sap;
          conn_stn_nxt = cmd.peer_station;
          emit         = 1'b1;
          emit_ctrl    = CC_ACP;
        end else if (cur_r == ST_CONNECTED) begin
          // A repeated request from the current peer is acknowledged again.
          emit      = 1'b1;
          emit_ctrl = (conn_stn_r == cmd.peer_station && conn_sap_r == cmd.peer_sap)
                      ? CC_ACP : CC_REJ;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    ovalid_nxt = ovalid_r;
    send_nxt   = send_r;
    stn_nxt    = stn_r;
    dsap_nxt   = dsap_r;
    ssap_nxt   = ssap_r;
    ctrl_nxt   = ctrl_r;
    stat_nxt   = stat_r;
    if (exec) begin
      ovalid_nxt = 1'b1;
      send_nxt   = emit;
      stn_nxt    = emit ? emit_stn : '0;
      dsap_nxt   = emit ? emit_sap : '0;
      ssap_nxt   = emit ? local_sap : '0;
      ctrl_nxt   = emit ? emit_ctrl : CC_UI;
      stat_nxt   = cur_nxt;
    end else if (out_ready) begin
      ovalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r      <= ST_SLEEPING;
      prev_r     <= ST_SLEEPING;
      conn_sap_r <= '0;
      conn_stn_r <= '0;
      ovalid_r   <= 1'b0;
    end else begin
      ovalid_r <= ovalid_nxt;
      if (exec) begin
        cur_r      <= cur_nxt;
        prev_r     <= prev_nxt;
        conn_sap_r <= conn_sap_nxt;
        conn_stn_r <= conn_stn_nxt;
      end
    end
    send_r <= send_nxt;
    stn_r  <= stn_nxt;
    dsap_r <= dsap_nxt;
    ssap_r <= ssap_nxt;
    ctrl_r <= ctrl_nxt;
    stat_r <= stat_nxt;
  end

  assign out_valid        = ovalid_r;
  assign out_send_valid   = send_r;
  assign out_send_station = stn_r;
  assign out_send_dst_sap = dsap_r;
  assign out_send_src_sap = ssap_r;
  assign out_send_control = ctrl_r;
  assign out_link_status  = stat_r;

endmodule

// ----- design/llc_sap_connection_control_unit.sv -----
// Connection control of one link-layer service access point.
// Use: events (listen, call, hangup, received control frame) enter on the
// in_ request channel; each yields exactly one result on the out_ channel
// with the new link status and an optional control frame to send.
// Both channels use valid/ready; an item moves when both are high.
// The accepted event passes the front decode register, then the command queue
// and then the result register, which drives the out_ channel.
// Throughput: one event per cycle while the receiver does not stall, set by the
// state update in the back end; the front end keeps accepting while a result waits.
// When the receiver stalls, the result register holds, the queue fills and
// then in_ready drops; nothing is lost or repeated.
// Configuration (local_sap, virtual_mode) is written through cfg_we with
// cfg_index and cfg_wdata, and must only change while the block is idle.
// Reset (rst_n low, synchronous) sets status sleeping, previous status
// sleeping, recorded peer zero, local_sap zero and virtual_mode one, and
// empties the pipeline.
// Depends on lscc_pkg, lscc_front, lscc_queue and lscc_back.
module llc_sap_connection_control_unit
  import lscc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [OP_W-1:0]       in_opcode,
  input  logic [SAP_W-1:0]      in_peer_sap,
  input  logic [STN_W-1:0]      in_peer_station,
  input  logic [CTRL_W-1:0]     in_control_code,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_send_valid,
  output logic [STN_W-1:0]      out_send_station,
  output logic [SAP_W-1:0]      out_send_dst_sap,
  output logic [SAP_W-1:0]      out_send_src_sap,
  output logic [CTRL_W-1:0]     out_send_control,
  output logic [1:0]            out_link_status
);

  logic [SAP_W-1:0] local_sap_r, local_sap_nxt;
  logic             vmode_r, vmode_nxt;

  logic fq_valid, fq_ready;
  cmd_t fq_cmd;
  logic qb_valid, qb_ready;
  cmd_t qb_cmd;

  always_comb begin
    local_sap_nxt = local_sap_r;
    vmode_nxt     = vmode_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_LOCAL_SAP:    local_sap_nxt = cfg_wdata[SAP_W-1:0];
        CFG_VIRTUAL_MODE: vmode_nxt     = cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      local_sap_r <= '0;
      vmode_r     <= 1'b1;
    end else begin
      local_sap_r <= local_sap_nxt;
      vmode_r     <= vmode_nxt;
    end
  end

  lscc_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .virtual_mode    (vmode_r),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_opcode       (in_opcode),
    .in_peer_sap     (in_peer_sap),
    .in_peer_station (in_peer_station),
    .in_control_code (in_control_code),
    .cmd_valid       (fq_valid),
    .cmd_ready       (fq_ready),
    .cmd             (fq_cmd)
  );

  lscc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_cmd   (fq_cmd),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_cmd    (qb_cmd)
  );

  lscc_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .local_sap        (local_sap_r),
    .cmd_valid        (qb_valid),
    .cmd_ready        (qb_ready),
    .cmd              (qb_cmd),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_send_valid   (out_send_valid),
    .out_send_station (out_send_station),
    .out_send_dst_sap (out_send_dst_sap),
    .out_send_src_sap (out_send_src_sap),
    .out_send_control (out_send_control),
    .out_link_status  (out_link_status)
  );

endmodule

// ----- tb/llc_sap_connection_control_unit_tb.sv -----
// Self-checking testbench for llc_sap_connection_control_unit: a directed table, then
// random phases over several configurations, idle patterns and one long receiver hold-off.
// Depends on lscc_pkg and the unit's RTL.
module llc_sap_connection_control_unit_tb;
  import lscc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned HOLD_CYCLES = 60;
  localparam int unsigned DIR_ROWS = 25;

  // Control codes with no meaning to the block.
  localparam logic [CTRL_W-1:0] CC_UNUSED_LO = 3'd5;
  localparam logic [CTRL_W-1:0] CC_UNUSED_HI = 3'd7;

  typedef struct packed {
    opcode_t             op;
    logic [SAP_W-1:0]    sap;
    logic [STN_W-1:0]    stn;
    logic [CTRL_W-1:0]   ctrl;
  } link_event_t;

  typedef struct packed {
    logic                send_valid;
    logic [STN_W-1:0]    station;
    logic [SAP_W-1:0]    dst_sap;
    logic [SAP_W-1:0]    src_sap;
    logic [CTRL_W-1:0]   control;
    status_t             status;
  } link_result_t;

  typedef struct packed {
    link_event_t         ev;
    logic                typed;
    link_result_t        want;
  } stim_row_t;

  // Rows with typed = 1 carry their expected result; the others use the predictor.
  localparam stim_row_t DIRECTED [DIR_ROWS] = '{
    '{'{OP_HANGUP, 8'h00, 8'h00, CC_UI},        1'b1,
      '{1'b0, 8'h00, 8'h00, 8'h00, CC_UI, ST_SLEEPING}},
    '{'{OP_FRAME,  8'h12, 8'h34, CC_REQ},       1'b1,
      '{1'b0, 8'h00, 8'h00, 8'h00, CC_UI, ST_SLEEPING}},
    '{'{OP_FRAME,  8'h12, 8'h34, CC_REJ},       1'b0, '0},
    '{'{OP_LISTEN, 8'hFF, 8'hFF, CC_UNUSED_HI}, 1'b1,
      '{1'b0, 8'h00, 8'h00, 8'h00, CC_UI, ST_LISTENING}},
    '{'{OP_LISTEN, 8'h00, 8'h00, CC_UI},        1'b1,
      '{1'b0, 8'h00, 8'h00, 8'h00, CC_UI, ST_LISTENING}},
    '{'{OP_FRAME,  8'hFF, 8'hFF, CC_REQ},       1'b1,
      '{1'b1, 8'hFF, 8'hFF, 8'h00, CC_ACP, ST_CONNECTED}},
    '{'{OP_FRAME,  8'hFF, 8'hFF, CC_REQ},       1'b1,
      '{1'b1, 8'hFF, 8'hFF, 8'h00, CC_ACP, ST_CONNECTED}},
    '{'{OP_FRAME,  8'h00, 8'hFF, CC_REQ},       1'b1,
      '{1'b1, 8'hFF, 8'h00, 8'h00, CC_REJ, ST_CONNECTED}},
    '{'{OP_FRAME,  8'hFF, 8'h00, CC_REQ},       1'b1,
      '{1'b1, 8'h00, 8'hFF, 8'h00, CC_REJ, ST_CONNECTED}},
    '{'{OP_FRAME,  8'hFF, 8'hFF, CC_UI},        1'b1,
      '{1'b0, 8'h00, 8'h00, 8'h00, CC_UI, ST_CONNECTED}},
    '{'{OP_FRAME,  8'hFF, 8'hFF, CC_DISC},      1'b1,
      '{1'b0, 8'h00, 8'h00, 8'h00, CC_UI, ST_CONNECTED}},
    '{'{OP_FRAME,  8'h80, 8'h01, CC_UNUSED_LO}, 1'b0, '0},
    '{'{OP_FRAME,  8'h01, 8'h80, CC_UNUSED_HI}, 1'b0, '0},
    '{'{OP_HANGUP, 8'h00, 8'h00, CC_UNUSED_HI}, 1'b1,
      '{1'b1, 8'hFF, 8'hFF, 8'h00, CC_DISC, ST_LISTENING}},
    '{'{OP_HANGUP, 8'hFF, 8'hFF, CC_UI},        1'b1,
      '{1'b0, 8'h00, 8'h00, 8'h00, CC_UI, ST_LISTENING}},
    '{'{OP_CALL,   8'h00, 8'h00, CC_UI},        1'b1,
      '{1'b1, 8'h00, 8'h00, 8'h00, CC_REQ, ST_CONNECTING}},
    '{'{OP_FRAME,  8'h00, 8'h00, CC_REJ},       1'b1,
      '{1'b0, 8'h00, 8'h00, 8'h00, CC_UI, ST_LISTENING}},
    '{'{OP_CALL,   8'h5A, 8'hA5, CC_UNUSED_LO}, 1'b0, '0},
    '{'{OP_FRAME,  8'h33, 8'h44, CC_ACP},       1'b1,
      '{1'b0, 8'h00, 8'h00, 8'h00, CC_UI, ST_CONNECTED}},
    '{'{OP_HANGUP, 8'h00, 8'h00, CC_UI},        1'b1,
      '{1'b1, 8'hA5, 8'h5A, 8'h00, CC_DISC, ST_CONNECTING}},
    '{'{OP_FRAME,  8'h00, 8'h00, CC_ACP},       1'b0, '0},
    '{'{OP_FRAME,  8'h00, 8'h00, CC_REQ},       1'b0, '0},
    '{'{OP_FRAME,  8'h00, 8'h00, CC_REJ},       1'b0, '0},
    '{'{OP_CALL,   8'hFF, 8'h00, CC_UNUSED_HI}, 1'b0, '0},
    '{'{OP_LISTEN, 8'h00, 8'h00, CC_UI},        1'b0, '0}
  };

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_LOCAL_SAP;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [OP_W-1:0]       in_opcode = '0;
  logic [SAP_W-1:0]      in_peer_sap = '0;
  logic [STN_W-1:0]      in_peer_station = '0;
  logic [CTRL_W-1:0]     in_control_code = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  out_send_valid;
  logic [STN_W-1:0]      out_send_station;
  logic [SAP_W-1:0]      out_send_dst_sap;
  logic [SAP_W-1:0]      out_send_src_sap;
  logic [CTRL_W-1:0]     out_send_control;
  logic [1:0]            out_link_status;

  llc_sap_connection_control_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_opcode        (in_opcode),
    .in_peer_sap      (in_peer_sap),
    .in_peer_station  (in_peer_station),
    .in_control_code  (in_control_code),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_send_valid   (out_send_valid),
    .out_send_station (out_send_station),
    .out_send_dst_sap (out_send_dst_sap),
    .out_send_src_sap (out_send_src_sap),
    .out_send_control (out_send_control),
    .out_link_status  (out_link_status)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Predicted link state and configuration.
  status_t          lk_status = ST_SLEEPING;
  status_t          lk_prev = ST_SLEEPING;
  logic [SAP_W-1:0] lk_peer_sap = '0;
  logic [STN_W-1:0] lk_peer_stn = '0;
  logic [SAP_W-1:0] lk_local_sap = '0;
  logic             lk_vmode = 1'b1;

  link_result_t pending_results[$];
  int unsigned  snd_idle_pct = 0;
  int unsigned  rcv_stall_pct = 0;
  bit           hold_req = 1'b0;
  int unsigned  cycle_count = 0;
  int unsigned  requests_sent = 0;
  int unsigned  results_seen = 0;
  int unsigned  frames_seen = 0;
  int unsigned  mismatches = 0;
  int unsigned  configs_used = 1;

  function automatic link_result_t frame_to(logic [STN_W-1:0] stn, logic [SAP_W-1:0] sap,
                                            logic [CTRL_W-1:0] cc);
    link_result_t r;
    r = '0;
    r.send_valid = 1'b1;
    r.station = stn;
    r.dst_sap = sap;
    r.src_sap = lk_local_sap;
    r.control = cc;
    return r;
  endfunction

  // Applies one event to the predicted state and returns the result it yields.
  function automatic link_result_t link_step(link_event_t ev);
    link_result_t r;
    r = '0;
    case (ev.op)
      OP_LISTEN: begin
        if (lk_status == ST_SLEEPING && lk_vmode) begin
          lk_prev = lk_status;
          lk_status = ST_LISTENING;
        end
      end
      OP_CALL: begin
        r = frame_to(ev.stn, ev.sap, CC_REQ);
        lk_peer_sap = ev.sap;
        lk_peer_stn = ev.stn;
        lk_prev = lk_status;
        lk_status = ST_CONNECTING;
      end
      OP_HANGUP: begin
        if (lk_status == ST_CONNECTED) begin
          r = frame_to(lk_peer_stn, lk_peer_sap, CC_DISC);
          lk_status = lk_prev;
        end
      end
      default: begin
        // In datagram mode received frames do not touch the connection.
        if (lk_vmode) begin
          case (ev.ctrl)
            CC_ACP: begin
              lk_prev = lk_status;
              lk_status = ST_CONNECTED;
            end
            CC_REJ: lk_status = lk_prev;
            CC_REQ: begin
              if (lk_status == ST_LISTENING) begin
                lk_prev = lk_status;
                lk_status = ST_CONNECTED;
                lk_peer_sap = ev.sap;
                lk_peer_stn = ev.stn;
                r = frame_to(ev.stn, ev.sap, CC_ACP);
              end else if (lk_status == ST_CONNECTED) begin
                r = frame_to(ev.stn, ev.sap,
                             (ev.stn == lk_peer_stn && ev.sap == lk_peer_sap) ? CC_ACP : CC_REJ);
              end
            end
            default: ;
          endcase
        end
      end
    endcase
    r.status = lk_status;
    return r;
  endfunction

  function automatic link_event_t pick_event();
    link_event_t ev;
    int unsigned k;
    ev.op   = opcode_t'($urandom_range(0, 3));
    ev.sap  = 8'($urandom_range(0, 255));
    ev.stn  = 8'($urandom_range(0, 255));
    ev.ctrl = 3'($urandom_range(0, 7));
    k = $urandom_range(0, 3);
    // Most requests follow the connection handshake so that every status is reached;
    // the rest are unconstrained.
    if ($urandom_range(0, 99) < 70) begin
      case (lk_status)
        ST_SLEEPING: ev.op = (k == 0) ? OP_CALL : OP_LISTEN;
        ST_LISTENING: begin
          if (k == 0) begin
            ev.op = OP_CALL;
          end else begin
            ev.op = OP_FRAME;
            ev.ctrl = CC_REQ;
          end
        end
        ST_CONNECTING: begin
          ev.op = OP_FRAME;
          ev.ctrl = (k == 0) ? CC_REJ : CC_ACP;
        end
        default: begin
          ev.op = (k == 0) ? OP_HANGUP : OP_FRAME;
          if (k != 3) ev.ctrl = CC_REQ;
          // Repeat requests from the recorded peer, and near misses on one field.
          if (k == 1 || k == 2) ev.sap = lk_peer_sap;
          if (k == 1 || $urandom_range(0, 3) == 0) ev.stn = lk_peer_stn;
        end
      endcase
    end
    return ev;
  endfunction

  // Called at a rising edge; returns at the edge where the request is accepted.
  task automatic send_event(input link_event_t ev, input logic typed, input link_result_t want);
    link_result_t predicted;
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_opcode       <= ev.op;
    in_peer_sap     <= ev.sap;
    in_peer_station <= ev.stn;
    in_control_code <= ev.ctrl;
    do @(negedge clk); while (!in_ready);
    predicted = link_step(ev);
    pending_results.push_back(typed ? want : predicted);
    requests_sent++;
    @(posedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic set_link_config(input logic [SAP_W-1:0] sap_id,
                                 input logic [CFG_DATA_W-1:0] mode_word);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_LOCAL_SAP;
    cfg_wdata <= sap_id;
    @(posedge clk);
    lk_local_sap = sap_id;
    cfg_index <= CFG_VIRTUAL_MODE;
    cfg_wdata <= mode_word;
    @(posedge clk);
    lk_vmode = mode_word[0];
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(input logic [SAP_W-1:0] sap_id, input logic mode,
                           input int unsigned idle_pct, input int unsigned stall_pct,
                           input int unsigned n, input bit squeeze);
    link_result_t none;
    logic [CFG_DATA_W-1:0] mode_word;
    none = '0;
    // Upper bits of the mode write are don't-care and get random values.
    mode_word = {7'($urandom_range(0, 127)), mode};
    wait_idle();
    set_link_config(sap_id, mode_word);
    configs_used++;
    snd_idle_pct = idle_pct;
    rcv_stall_pct = stall_pct;
    if (squeeze) hold_req = 1'b1;
    repeat (n) send_event(pick_event(), 1'b0, none);
  endtask

  // Receiver: random stalls, plus one long hold-off counted here.
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= rcv_stall_pct);
      end
    end
  end

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  // Outputs are stable at the falling edge; a result seen here moves at the next rising edge.
  always @(negedge clk) begin : result_check
    link_result_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (out_send_valid) frames_seen++;
      if (pending_results.size() == 0) begin
        $error("result with no request outstanding");
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("send_valid", want.send_valid, out_send_valid);
        check_field("send_station", want.station, out_send_station);
        check_field("send_dst_sap", want.dst_sap, out_send_dst_sap);
        check_field("send_src_sap", want.src_sap, out_send_src_sap);
        check_field("send_control", want.control, out_send_control);
        check_field("link_status", want.status, out_link_status);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    foreach (DIRECTED[i]) send_event(DIRECTED[i].ev, DIRECTED[i].typed, DIRECTED[i].want);

    run_phase(8'hFF, 1'b1, 0, 0, 110, 1'b0);
    run_phase(8'h00, 1'b0, 50, 0, 70, 1'b0);
    run_phase(8'h5A, 1'b1, 0, 50, 110, 1'b0);
    run_phase(8'hFF, 1'b0, 33, 33, 60, 1'b0);
    run_phase(8'($urandom_range(0, 255)), 1'b1, 33, 33, 120, 1'b0);
    run_phase(8'($urandom_range(0, 255)), 1'b1, 0, 0, 100, 1'b1);
    run_phase(8'h00, 1'b1, 50, 50, 80, 1'b0);

    wait_idle();
    repeat (8) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      mismatches++;
    end
    $display("Sent %0d requests over %0d configurations, checked %0d results (%0d with frames).",
             requests_sent, configs_used, results_seen, frames_seen);
    $display("Mismatches: %0d", mismatches);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
